@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ITF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check an implication within the same cycle
`define ITF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/itf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package itf_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int MAX_FIELD_DEF   = 48;
	localparam int DIGIT_STORE_DEF = 36;

	localparam int BASE_W  = 6;
	localparam int FIELD_W = 6;
	localparam int CHAR_W  = 8;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIVIDE,
		S_SIZE,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SRC_LEAD,
		SRC_SIGN,
		SRC_PREFIX,
		SRC_ZERO,
		SRC_DIGIT,
		SRC_TRAIL
	} src_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d,
		input logic lower);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-BASE_W){1'b0}}, d};
		if (d < 6'd10) begin
			digit_char = CH_ZERO + ext;
		end else begin
			digit_char = (lower ? CH_LOWER : CH_UPPER) + ext - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/itf_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itf_divider #(
	parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [VALUE_BITS-1:0]     dividend,
	input  wire logic [itf_pkg::BASE_W-1:0] divisor,
	output logic                           done,
	output logic [VALUE_BITS-1:0]          quotient,
	output logic [itf_pkg::BASE_W-1:0]     remainder
);
	import itf_pkg::*;

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [BASE_W-1:0]     rem_q;
	logic [BASE_W-1:0]     div_q;

	logic [BASE_W:0] trial;
	logic [BASE_W:0] nrem;
	logic            ge;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		ge    = trial >= {1'b0, div_q};
		nrem  = ge ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= nrem[BASE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/integer_to_text_formatter.sv @@
// All digits are produced before the first character, each by one full bit-serial
// pass of the shared divider; a bad base goes from idle straight to the emit state
// and gives its single word.
// Throughput: one character per cycle in emission unless out_stall holds it; the input
// stays stalled from acceptance until the final character is in the output register.
// Reset: asynchronous, active low; clears the sequencer, counters and output valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_text_formatter #(
	parameter int VALUE_BITS  = itf_pkg::VALUE_BITS_DEF,
	parameter int MAX_FIELD   = itf_pkg::MAX_FIELD_DEF,
	parameter int DIGIT_STORE = itf_pkg::DIGIT_STORE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [VALUE_BITS-1:0]       value,
	input  wire logic [itf_pkg::BASE_W-1:0]  number_base,
	input  wire logic [itf_pkg::FIELD_W-1:0] min_width,
	input  wire logic [itf_pkg::FIELD_W-1:0] min_digits,
	input  wire logic                        zero_pad,
	input  wire logic                        is_signed,
	input  wire logic                        show_plus,
	input  wire logic                        space_sign,
	input  wire logic                        left_justify,
	input  wire logic                        alt_prefix,
	input  wire logic                        lower_case,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [itf_pkg::CHAR_W-1:0]       out_char,
	output logic                             last_char,
	output logic                             bad_base
);
	import itf_pkg::*;

	localparam int DIGIT_CAP = (DIGIT_STORE > VALUE_BITS) ? DIGIT_STORE : VALUE_BITS;
	localparam int DN_W      = $clog2(DIGIT_CAP + 1);
	localparam int CNT_W     = $clog2(3 * MAX_FIELD + 64 + DIGIT_CAP + 4) + 1;
	localparam int EM_W      = $clog2(MAX_FIELD);

	state_t state_q, state_d;

	logic                  div_active_q;
	logic [DN_W-1:0]       dig_n_q;
	logic [CNT_W-1:0]      lead_q, zero_q, trail_q, left_q;
	logic                  sgn_q;
	logic [1:0]            pfx_q;
	logic [EM_W-1:0]       emit_q;
	logic                  bad_q;
	logic                  out_valid_q;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BASE_W-1:0]     base_q;
	logic [CNT_W-1:0]      fw_q, prec_q;
	logic                  zp_q, lj_q, lower_q, hex_q;
	logic [CHAR_W-1:0]     sign_ch_q;
	logic [BASE_W-1:0]     dig_q [DIGIT_CAP];
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q, out_bad_q;

	logic                  accept;
	logic                  base_bad;
	logic                  neg;
	logic                  div_start, div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [BASE_W-1:0]     div_rem;
	logic                  div_finish;
	logic                  fire;
	logic                  last_now;
	src_t                  src;
	logic [CHAR_W-1:0]     ch;

	logic [CNT_W-1:0] dig_ext, precx, size, possz, pfx_len, sgn_len;

	itf_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (base_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	assign base_bad   = (number_base < BASE_MIN) || (number_base > BASE_MAX);
	assign neg        = is_signed && value[VALUE_BITS-1];
	assign div_finish = (div_quot == '0) || (dig_n_q == DN_W'(DIGIT_CAP - 1));

	always_comb begin
		dig_ext = CNT_W'(dig_n_q);
		precx   = (dig_ext > prec_q) ? dig_ext : prec_q;
		sgn_len = CNT_W'(sgn_q);
		pfx_len = CNT_W'(pfx_q);
		size    = fw_q - sgn_len - pfx_len - precx;
		possz   = size[CNT_W-1] ? '0 : size;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = base_bad ? S_EMIT : S_DIVIDE;
				end
			end
			S_DIVIDE: begin
				if (div_done && div_finish) begin
					state_d = S_SIZE;
				end
			end
			S_SIZE: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (fire && last_now) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		accept    = in_valid && (state_q == S_IDLE);
		div_start = (state_q == S_DIVIDE) && !div_active_q;
		fire      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
		last_now  = (left_q == CNT_W'(1)) || (emit_q == EM_W'(MAX_FIELD - 1)) || bad_q;
		if (lead_q != '0) begin
			src = SRC_LEAD;
		end else if (sgn_q) begin
			src = SRC_SIGN;
		end else if (pfx_q != 2'd0) begin
			src = SRC_PREFIX;
		end else if (zero_q != '0) begin
			src = SRC_ZERO;
		end else if (dig_n_q != '0) begin
			src = SRC_DIGIT;
		end else begin
			src = SRC_TRAIL;
		end
		case (src)
			SRC_LEAD:   ch = CH_SPACE;
			SRC_SIGN:   ch = sign_ch_q;
			SRC_PREFIX: begin
				if (pfx_q == 2'd1 && hex_q) begin
					ch = lower_q ? CH_X_LO : CH_X_UP;
				end else begin
					ch = CH_ZERO;
				end
			end
			SRC_ZERO:   ch = CH_ZERO;
			SRC_DIGIT:  ch = digit_char(dig_q[0], lower_q);
			SRC_TRAIL:  ch = CH_SPACE;
			default:    ch = CH_SPACE;
		endcase
		if (bad_q) begin
			ch = CH_NUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			div_active_q <= 1'b0;
			dig_n_q      <= '0;
			lead_q       <= '0;
			zero_q       <= '0;
			trail_q      <= '0;
			left_q       <= '0;
			sgn_q        <= 1'b0;
			pfx_q        <= 2'd0;
			emit_q       <= '0;
			bad_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= fire || (out_valid_q && out_stall);
			if (accept) begin
				bad_q        <= base_bad;
				div_active_q <= 1'b0;
				dig_n_q      <= '0;
				lead_q       <= '0;
				zero_q       <= '0;
				trail_q      <= '0;
				left_q       <= base_bad ? CNT_W'(1) : '0;
				emit_q       <= '0;
				sgn_q        <= !base_bad && (neg || show_plus || space_sign);
				if (!base_bad && alt_prefix && number_base == BASE_HEX) begin
					pfx_q <= 2'd2;
				end else if (!base_bad && alt_prefix && number_base == BASE_OCT) begin
					pfx_q <= 2'd1;
				end else begin
					pfx_q <= 2'd0;
				end
			end
			if (div_start) begin
				div_active_q <= 1'b1;
			end
			if (div_done) begin
				div_active_q <= 1'b0;
				dig_n_q      <= dig_n_q + 1'b1;
			end
			if (state_q == S_SIZE) begin
				lead_q  <= (!zp_q && !lj_q) ? possz : '0;
				zero_q  <= (zp_q ? possz : '0) + (precx - dig_ext);
				trail_q <= lj_q ? possz : '0;
				left_q  <= ((!zp_q && !lj_q) ? possz : '0) + sgn_len + pfx_len
					+ (zp_q ? possz : '0) + precx + (lj_q ? possz : '0);
			end
			if (fire) begin
				emit_q <= emit_q + 1'b1;
				left_q <= left_q - 1'b1;
				case (src)
					SRC_LEAD:   lead_q  <= lead_q - 1'b1;
					SRC_SIGN:   sgn_q   <= 1'b0;
					SRC_PREFIX: pfx_q   <= pfx_q - 2'd1;
					SRC_ZERO:   zero_q  <= zero_q - 1'b1;
					SRC_DIGIT:  dig_n_q <= dig_n_q - 1'b1;
					SRC_TRAIL: begin
						if (trail_q != '0) begin
							trail_q <= trail_q - 1'b1;
						end
					end
					default: begin
						lead_q <= lead_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= neg ? (VALUE_BITS'(0) - value) : value;
			base_q    <= number_base;
			fw_q      <= (CNT_W'(min_width) > CNT_W'(MAX_FIELD)) ?
				CNT_W'(MAX_FIELD) : CNT_W'(min_width);
			prec_q    <= CNT_W'(min_digits);
			zp_q      <= zero_pad && !left_justify;
			lj_q      <= left_justify;
			lower_q   <= lower_case;
			hex_q     <= (number_base == BASE_HEX);
			sign_ch_q <= neg ? CH_MINUS : (show_plus ? CH_PLUS : CH_SPACE);
		end
		if (div_done) begin
			mag_q <= div_quot;
		end
		if (fire) begin
			out_char_q <= ch;
			out_last_q <= last_now;
			out_bad_q  <= bad_q;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			dig_q[0] <= div_rem;
			for (int j = 1; j < DIGIT_CAP; j++) begin
				dig_q[j] <= dig_q[j-1];
			end
		end else if (fire && src == SRC_DIGIT && !bad_q) begin
			for (int j = 0; j < DIGIT_CAP - 1; j++) begin
				dig_q[j] <= dig_q[j+1];
			end
			dig_q[DIGIT_CAP-1] <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = out_last_q;
	assign bad_base  = out_bad_q;

	`include "assert_macros.svh"

	`ITF_ASSERT_IMPLY(a_bad_single, out_valid && bad_base, last_char && out_char == CH_NUL, "bad base word malformed")
	`ITF_ASSERT_IMPLY(a_div_in_divide, div_done, state_q == S_DIVIDE, "divider result outside divide phase")
	`ITF_ASSERT_ALWAYS(a_emit_pending, !(state_q == S_EMIT && left_q == '0), "emit phase with nothing left")

endmodule

`default_nettype wire
